// ===== rtl/rhc_pkg.sv =====
// ----------------------------------------------------------------------------
// rhc_pkg: shared types and constants for the rgb to hsv converter
// Channel and field widths, hue sector codes, hue offsets and divider sizing.
// ----------------------------------------------------------------------------
package rhc_pkg;

   localparam int CH_W         = 8;
   localparam int HUE_W        = 16;
   localparam int SAT_W        = 17;
   localparam int SAT_FRAC     = 16;
   localparam int REQ_TDATA_W  = 24;
   localparam int RSP_TDATA_W  = 48;

   // dividend width shared by both dividers (delta << 16 and 7680 * |diff|)
   localparam int DIV_NUM_W          = 24;
   localparam int DIV_BITS_PER_STAGE = 4;

   localparam int FRONT_STAGES = 2;
   localparam int BACK_STAGES  = 1;

   // hue units per 60 degree sector
   localparam int HUE_SCALE = 7680;

   // sector offsets in 1/128 degree units
   localparam logic [HUE_W-1:0] HUE_BASE_RED   = 16'd0;
   localparam logic [HUE_W-1:0] HUE_BASE_GREEN = 16'd15360;
   localparam logic [HUE_W-1:0] HUE_BASE_BLUE  = 16'd30720;
   localparam logic [HUE_W-1:0] HUE_BASE_WRAP  = 16'd46080;

   typedef enum logic [1:0] {
      SEC_RED   = 2'd0,
      SEC_GREEN = 2'd1,
      SEC_BLUE  = 2'd2
   } sector_type;

   typedef struct packed {
      logic       gray;
      sector_type sector;
      logic       neg;
   } hue_tag_type;

endpackage

// ===== rtl/rhc_ctrl.sv =====
// ----------------------------------------------------------------------------
// rhc_ctrl: pipeline valid tracking
// Keeps one valid bit per stage and gives each stage its load enable, so that
// bubbles are squeezed out while the result side is stalled.
// ----------------------------------------------------------------------------
module rhc_ctrl #(
   parameter int STAGES = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [STAGES-1:0] stage_en
);
   import rhc_pkg::*;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] upstream;

   // a stage may load when it is empty or its content moves on
   always_comb begin
      logic downstream;
      downstream = rsp_tready;
      for (int k = STAGES - 1; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || downstream;
         downstream  = stage_en[k];
      end
   end

   assign upstream = {valid_ff[STAGES-2:0], req_tvalid};
   assign valid_in = (stage_en & upstream) | (~stage_en & valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = stage_en[0];
   assign rsp_tvalid = valid_ff[STAGES-1];

endmodule

// ===== rtl/rhc_front.sv =====
// ----------------------------------------------------------------------------
// rhc_front: channel max/min, hue sector and divider operands
// Stage one finds max, min and the sector; stage two forms delta, the signed
// sector difference and both dividends.
// ----------------------------------------------------------------------------
module rhc_front (
   input  logic                           clock,
   input  logic [1:0]                     en,
   input  logic [rhc_pkg::CH_W-1:0]       red,
   input  logic [rhc_pkg::CH_W-1:0]       green,
   input  logic [rhc_pkg::CH_W-1:0]       blue,
   output logic [rhc_pkg::DIV_NUM_W-1:0]  sat_num,
   output logic [rhc_pkg::DIV_NUM_W-1:0]  hue_num,
   output logic [rhc_pkg::CH_W-1:0]       max_out,
   output logic [rhc_pkg::CH_W-1:0]       delta_out,
   output rhc_pkg::hue_tag_type           hue_tag
);
   import rhc_pkg::*;

   // stage one
   logic [CH_W-1:0] mx_in, mn_in;
   sector_type      sec_in;
   logic [CH_W-1:0] r1_ff, g1_ff, b1_ff, mx1_ff, mn1_ff;
   sector_type      sec1_ff;

   always_comb begin
      mx_in = red;
      mn_in = red;
      if (green > mx_in) mx_in = green;
      if (blue > mx_in)  mx_in = blue;
      if (green < mn_in) mn_in = green;
      if (blue < mn_in)  mn_in = blue;
      if (mx_in == red) begin
         sec_in = SEC_RED;
      end else if (mx_in == green) begin
         sec_in = SEC_GREEN;
      end else begin
         sec_in = SEC_BLUE;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         r1_ff   <= red;
         g1_ff   <= green;
         b1_ff   <= blue;
         mx1_ff  <= mx_in;
         mn1_ff  <= mn_in;
         sec1_ff <= sec_in;
      end
   end

   // stage two
   logic [CH_W-1:0]      delta_in, op_a, op_b, absdiff;
   logic                 neg_in;
   logic [DIV_NUM_W-1:0] sat_num_in, hue_num_in;
   hue_tag_type          tag_in;
   logic [DIV_NUM_W-1:0] sat_num_ff, hue_num_ff;
   logic [CH_W-1:0]      mx2_ff, delta2_ff;
   hue_tag_type          tag2_ff;

   always_comb begin
      delta_in = mx1_ff - mn1_ff;
      unique case (sec1_ff)
         SEC_RED: begin
            op_a = g1_ff;
            op_b = b1_ff;
         end
         SEC_GREEN: begin
            op_a = b1_ff;
            op_b = r1_ff;
         end
         SEC_BLUE: begin
            op_a = r1_ff;
            op_b = g1_ff;
         end
         default: begin
            op_a = g1_ff;
            op_b = b1_ff;
         end
      endcase
      neg_in     = op_a < op_b;
      absdiff    = neg_in ? (op_b - op_a) : (op_a - op_b);
      hue_num_in = DIV_NUM_W'(absdiff) * DIV_NUM_W'(HUE_SCALE);
      sat_num_in = DIV_NUM_W'(delta_in) << SAT_FRAC;
      tag_in.gray   = (delta_in == '0);
      tag_in.sector = sec1_ff;
      tag_in.neg    = neg_in;
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         sat_num_ff <= sat_num_in;
         hue_num_ff <= hue_num_in;
         mx2_ff     <= mx1_ff;
         delta2_ff  <= delta_in;
         tag2_ff    <= tag_in;
      end
   end

   assign sat_num   = sat_num_ff;
   assign hue_num   = hue_num_ff;
   assign max_out   = mx2_ff;
   assign delta_out = delta2_ff;
   assign hue_tag   = tag2_ff;

endmodule

// ===== rtl/rhc_div.sv =====
// ----------------------------------------------------------------------------
// rhc_div: pipelined restoring divider
// Unsigned quotient of a NUM_W-bit dividend by a DEN_W-bit divisor, BPS
// quotient bits per stage, with a tag carried alongside each operand.
// ----------------------------------------------------------------------------
module rhc_div #(
   parameter int NUM_W = rhc_pkg::DIV_NUM_W,
   parameter int DEN_W = rhc_pkg::CH_W,
   parameter int BPS   = rhc_pkg::DIV_BITS_PER_STAGE,
   parameter int TAG_W = 1
) (
   input  logic                              clock,
   input  logic [(NUM_W+BPS-1)/BPS-1:0]      en,
   input  logic [NUM_W-1:0]                  num_in,
   input  logic [DEN_W-1:0]                  den_in,
   input  logic [TAG_W-1:0]                  tag_in,
   output logic [NUM_W-1:0]                  quot_out,
   output logic [TAG_W-1:0]                  tag_out
);
   import rhc_pkg::*;

   localparam int STAGES = (NUM_W + BPS - 1) / BPS;
   localparam int PAD_W  = STAGES * BPS;

   // dividend bits shift out at the top while quotient bits shift in below
   logic [PAD_W-1:0] nq_ff  [STAGES];
   logic [DEN_W-1:0] rem_ff [STAGES];
   logic [DEN_W-1:0] den_ff [STAGES];
   logic [TAG_W-1:0] tag_ff [STAGES];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic [PAD_W-1:0] nq_src, nq_in;
      logic [DEN_W-1:0] rem_src, rem_in, den_src;
      logic [TAG_W-1:0] tag_src;

      if (s == 0) begin : g_first
         assign nq_src  = PAD_W'(num_in);
         assign rem_src = '0;
         assign den_src = den_in;
         assign tag_src = tag_in;
      end else begin : g_next
         assign nq_src  = nq_ff[s-1];
         assign rem_src = rem_ff[s-1];
         assign den_src = den_ff[s-1];
         assign tag_src = tag_ff[s-1];
      end

      always_comb begin
         logic [DEN_W:0] trial;
         trial  = '0;
         nq_in  = nq_src;
         rem_in = rem_src;
         for (int i = 0; i < BPS; i++) begin
            trial = {rem_in, nq_in[PAD_W-1]};
            nq_in = {nq_in[PAD_W-2:0], 1'b0};
            if (trial >= {1'b0, den_src}) begin
               trial    = trial - {1'b0, den_src};
               nq_in[0] = 1'b1;
            end
            rem_in = trial[DEN_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (en[s]) begin
            nq_ff[s]  <= nq_in;
            rem_ff[s] <= rem_in;
            den_ff[s] <= den_src;
            tag_ff[s] <= tag_src;
         end
      end
   end

   assign quot_out = nq_ff[STAGES-1][NUM_W-1:0];
   assign tag_out  = tag_ff[STAGES-1];

endmodule

// ===== rtl/rhc_back.sv =====
// ----------------------------------------------------------------------------
// rhc_back: hue assembly and output register
// Adds the sector offset to the signed quotient, clears gray and black cases
// and holds the packed result until it is taken.
// ----------------------------------------------------------------------------
module rhc_back (
   input  logic                              clock,
   input  logic                              en,
   input  logic [rhc_pkg::DIV_NUM_W-1:0]     sat_quot,
   input  logic [rhc_pkg::CH_W-1:0]          brightness,
   input  logic [rhc_pkg::DIV_NUM_W-1:0]     hue_quot,
   input  rhc_pkg::hue_tag_type              hue_tag,
   output logic [rhc_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import rhc_pkg::*;

   logic [HUE_W-1:0] base, hue_q, hue_in;
   logic [SAT_W-1:0] sat_in;
   logic [HUE_W-1:0] hue_ff;
   logic [SAT_W-1:0] sat_ff;
   logic [CH_W-1:0]  bright_ff;

   always_comb begin
      unique case (hue_tag.sector)
         SEC_RED:   base = hue_tag.neg ? HUE_BASE_WRAP : HUE_BASE_RED;
         SEC_GREEN: base = HUE_BASE_GREEN;
         SEC_BLUE:  base = HUE_BASE_BLUE;
         default:   base = HUE_BASE_RED;
      endcase
      hue_q = hue_quot[HUE_W-1:0];
      if (hue_tag.gray) begin
         hue_in = '0;
      end else if (hue_tag.neg) begin
         hue_in = base - hue_q;
      end else begin
         hue_in = base + hue_q;
      end
      // black pixel: divider saw a zero divisor
      sat_in = (brightness == '0) ? '0 : sat_quot[SAT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hue_ff    <= hue_in;
         sat_ff    <= sat_in;
         bright_ff <= brightness;
      end
   end

   assign rsp_tdata = {(RSP_TDATA_W - HUE_W - SAT_W - CH_W)'(0), bright_ff, sat_ff, hue_ff};

endmodule

// ===== rtl/rgb_to_hsv_converter.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter: 8-bit rgb pixel to fixed-point hsv
// Usage:
//   req channel carries one pixel per request: red, green, blue.
//   rsp channel carries hue (1/128 degree), saturation (Q1.16) and brightness
//   (largest channel), one response for every request, in order.
//   Throughput is one pixel per clock while the response side is not
//   stalled. The two restoring dividers, with the default of four
//   quotient bits per divider stage, make up most of the pipeline.
//   Gray pixels give hue 0, black pixels also give saturation 0.
//   Reset clears all stage valid bits; the pipeline comes out empty and
//   ready. When rsp_tready is low the result register holds, and earlier
//   stages keep filling until every stage is full, so req_tready drops only
//   once no bubble is left in the pipeline. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter #(
   parameter int DIV_BPS = rhc_pkg::DIV_BITS_PER_STAGE
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [rhc_pkg::REQ_TDATA_W-1:0] req_tdata,  // red, green, blue
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [rhc_pkg::RSP_TDATA_W-1:0] rsp_tdata   // hue, saturation, brightness, zero pad
);
   import rhc_pkg::*;

   localparam int DIV_STAGES = (DIV_NUM_W + DIV_BPS - 1) / DIV_BPS;
   localparam int STAGES     = FRONT_STAGES + DIV_STAGES + BACK_STAGES;
   localparam int TAG_W      = $bits(hue_tag_type);

   logic [STAGES-1:0]    stage_en;
   logic [DIV_NUM_W-1:0] sat_num, hue_num, sat_quot, hue_quot;
   logic [CH_W-1:0]      max_val, delta_val, bright_d;
   hue_tag_type          hue_tag, hue_tag_d;
   logic [TAG_W-1:0]     hue_tag_bits;

   rhc_ctrl #(
      .STAGES(STAGES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stage_en   (stage_en)
   );

   rhc_front u_front (
      .clock     (clock),
      .en        (stage_en[FRONT_STAGES-1:0]),
      .red       (req_tdata[CH_W-1:0]),
      .green     (req_tdata[2*CH_W-1:CH_W]),
      .blue      (req_tdata[3*CH_W-1:2*CH_W]),
      .sat_num   (sat_num),
      .hue_num   (hue_num),
      .max_out   (max_val),
      .delta_out (delta_val),
      .hue_tag   (hue_tag)
   );

   rhc_div #(
      .NUM_W (DIV_NUM_W),
      .DEN_W (CH_W),
      .BPS   (DIV_BPS),
      .TAG_W (CH_W)
   ) u_sat_div (
      .clock    (clock),
      .en       (stage_en[FRONT_STAGES +: DIV_STAGES]),
      .num_in   (sat_num),
      .den_in   (max_val),
      .tag_in   (max_val),
      .quot_out (sat_quot),
      .tag_out  (bright_d)
   );

   rhc_div #(
      .NUM_W (DIV_NUM_W),
      .DEN_W (CH_W),
      .BPS   (DIV_BPS),
      .TAG_W (TAG_W)
   ) u_hue_div (
      .clock    (clock),
      .en       (stage_en[FRONT_STAGES +: DIV_STAGES]),
      .num_in   (hue_num),
      .den_in   (delta_val),
      .tag_in   (hue_tag),
      .quot_out (hue_quot),
      .tag_out  (hue_tag_bits)
   );

   assign hue_tag_d = hue_tag_type'(hue_tag_bits);

   rhc_back u_back (
      .clock      (clock),
      .en         (stage_en[STAGES-1]),
      .sat_quot   (sat_quot),
      .brightness (bright_d),
      .hue_quot   (hue_quot),
      .hue_tag    (hue_tag_d),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== rtl/rhc_checker.sv =====
// ----------------------------------------------------------------------------
// rhc_checker: port-level checks for the rgb to hsv converter
// Watches the response channel for stall behavior and field consistency.
// ----------------------------------------------------------------------------
module rhc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [rhc_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import rhc_pkg::*;

   logic [HUE_W-1:0] hue;
   logic [SAT_W-1:0] sat;
   logic [CH_W-1:0]  bright;

   assign hue    = rsp_tdata[HUE_W-1:0];
   assign sat    = rsp_tdata[HUE_W+SAT_W-1:HUE_W];
   assign bright = rsp_tdata[HUE_W+SAT_W+CH_W-1:HUE_W+SAT_W];

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (hue <= 16'd46079) && (sat <= 17'd65536))
      else $error("hue or saturation out of range");

   a_black: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (bright == '0) |-> (sat == '0) && (hue == '0))
      else $error("black pixel with nonzero hue or saturation");

   // zero saturation only arises from a gray pixel
   a_gray: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (sat == '0) |-> (hue == '0))
      else $error("gray pixel with nonzero hue");

endmodule

bind rgb_to_hsv_converter rhc_checker u_rhc_checker (.*);

// ===== bench/rgb_to_hsv_converter_check.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_check: response checker for the rgb to hsv converter
// Watches both stream channels, computes the expected hue, saturation and
// brightness for every accepted request and compares each response in order.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_check (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [rhc_pkg::REQ_TDATA_W-1:0] req_tdata,   // red, green, blue
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [rhc_pkg::RSP_TDATA_W-1:0] rsp_tdata,   // hue, saturation, brightness, zero pad
   output int                              fail_count,
   output int                              pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import rhc_pkg::*;

   typedef struct packed {
      logic [HUE_W-1:0] hue;
      logic [SAT_W-1:0] saturation;
      logic [CH_W-1:0]  brightness;
   } hsv_type;

   hsv_type hsv_queue[$];
   int      mismatches    = 0;
   int      pending_count = 0;

   assign fail_count = mismatches;
   assign pending    = pending_count;

   function automatic hsv_type convert_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                             logic [CH_W-1:0] b);
      int         red, green, blue;
      int         top, bottom, spread, diff, base, hue_sum;
      sector_type sector;
      hsv_type    hsv;
      red    = int'(r);
      green  = int'(g);
      blue   = int'(b);
      top    = red;
      bottom = red;
      if (green > top) top = green;
      if (blue > top) top = blue;
      if (green < bottom) bottom = green;
      if (blue < bottom) bottom = blue;
      spread = top - bottom;
      hsv.brightness = top[CH_W-1:0];
      hsv.saturation = (top == 0) ? '0 : SAT_W'((spread * (1 << SAT_FRAC)) / top);
      // sector priority on ties: red, then green, then blue
      if (top == red) sector = SEC_RED;
      else if (top == green) sector = SEC_GREEN;
      else sector = SEC_BLUE;
      case (sector)
         SEC_RED: begin
            diff = green - blue;
            base = (green >= blue) ? int'(HUE_BASE_RED) : int'(HUE_BASE_WRAP);
         end
         SEC_GREEN: begin
            diff = blue - red;
            base = int'(HUE_BASE_GREEN);
         end
         default: begin
            diff = red - green;
            base = int'(HUE_BASE_BLUE);
         end
      endcase
      if (spread == 0) begin
         hsv.hue = '0;
      end else begin
         // signed division truncates toward zero
         hue_sum = base + (HUE_SCALE * diff) / spread;
         hsv.hue = hue_sum[HUE_W-1:0];
      end
      return hsv;
   endfunction

   always @(posedge clock) begin
      hsv_type want, got;
      if (!reset) begin
         if (req_tvalid && req_tready)
            hsv_queue.push_back(convert_pixel(req_tdata[7:0], req_tdata[15:8],
                                              req_tdata[23:16]));
         if (rsp_tvalid && rsp_tready) begin
            got.hue        = rsp_tdata[15:0];
            got.saturation = rsp_tdata[32:16];
            got.brightness = rsp_tdata[40:33];
            if (hsv_queue.size() == 0) begin
               $display("%0t: unexpected response hue %0d sat %0d bright %0d", $time,
                        got.hue, got.saturation, got.brightness);
               mismatches++;
            end else begin
               want = hsv_queue.pop_front();
               if (got.hue !== want.hue) begin
                  $display("%0t: hue mismatch, expected %0d actual %0d", $time,
                           want.hue, got.hue);
                  mismatches++;
               end
               if (got.saturation !== want.saturation) begin
                  $display("%0t: saturation mismatch, expected %0d actual %0d", $time,
                           want.saturation, got.saturation);
                  mismatches++;
               end
               if (got.brightness !== want.brightness) begin
                  $display("%0t: brightness mismatch, expected %0d actual %0d", $time,
                           want.brightness, got.brightness);
                  mismatches++;
               end
            end
         end
      end
      pending_count <= hsv_queue.size();
   end

endmodule

// ===== bench/rgb_to_hsv_converter_test.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_test: stimulus and verdict for the rgb to hsv converter
// Sends directed corner pixels and then random pixels under varying
// backpressure and source gaps; the checker beside the block scores responses.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_test;
   timeunit 1ns;
   timeprecision 1ps;
   import rhc_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int STALL_CYCLES = 64;
   localparam int DRAIN_CYCLES = 24;
   localparam int RANDOM_COUNT = 430;

   logic                   clock         = 1'b0;
   logic                   reset         = 1'b1;
   logic                   req_tvalid    = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata     = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready    = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   stall_request = 1'b0;

   int fail_count;
   int pending;
   int send_idle_pct = 18;
   int recv_idle_pct = 79;
   int stall_left    = 0;
   int cycle_count   = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   rgb_to_hsv_converter uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   rgb_to_hsv_converter_check check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // response side backpressure, with an optional long hold-off
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stall_request) begin
         rsp_tready <= 1'b0;
         stall_left <= STALL_CYCLES;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                             input logic [CH_W-1:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {b, g, r};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_random_pixels(input int count);
      logic [CH_W-1:0] r, g, b;
      int              pick;
      repeat (count) begin
         r    = CH_W'($urandom);
         g    = CH_W'($urandom);
         b    = CH_W'($urandom);
         pick = $urandom_range(11);
         case (pick)
            0: begin
               g = r;
               b = r;
            end
            1: g = r;
            2: b = g;
            3: b = r;
            4: begin
               r = $urandom_range(1) ? 8'd255 : 8'd0;
               g = $urandom_range(1) ? 8'd255 : 8'd0;
               b = $urandom_range(1) ? 8'd255 : 8'd0;
            end
            5: begin
               // nearly gray: spread of zero to two codes, unless green wraps past 255
               g = CH_W'(r + $urandom_range(2));
               b = r;
            end
            default: ;
         endcase
         send_pixel(r, g, b);
      end
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_until_drained();
      // wait for a clock edge before the first look so the last accepted request is counted
      do @(posedge clock); while (pending != 0);
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** rgb_to_hsv_converter: FAILED **");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corner pixels: black, white, gray, primaries, ties and sector edges
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd1, 8'd1, 8'd1);
      send_pixel(8'd255, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd1);
      send_pixel(8'd255, 8'd1, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd255, 8'd0, 8'd255);
      send_pixel(8'd0, 8'd255, 8'd255);
      send_pixel(8'd1, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd1, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd1);
      send_pixel(8'd10, 8'd255, 8'd20);
      send_pixel(8'd20, 8'd255, 8'd10);
      send_pixel(8'd30, 8'd10, 8'd255);
      send_pixel(8'd10, 8'd30, 8'd255);
      send_pixel(8'd255, 8'd254, 8'd0);
      send_pixel(8'd254, 8'd0, 8'd255);
      send_pixel(8'd170, 8'd85, 8'd170);
      req_tvalid <= 1'b0;

      send_random_pixels(RANDOM_COUNT);
      wait_until_drained();

      send_idle_pct = 79;
      recv_idle_pct <= 18;
      send_random_pixels(RANDOM_COUNT);
      wait_until_drained();

      // no idling; a long response hold-off at the start fills the pipeline
      send_idle_pct = 0;
      recv_idle_pct <= 0;
      stall_request <= 1'b1;
      send_pixel(8'd200, 8'd100, 8'd50);
      stall_request <= 1'b0;
      send_random_pixels(RANDOM_COUNT);
      wait_until_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("** rgb_to_hsv_converter: PASSED **");
      else
         $display("** rgb_to_hsv_converter: FAILED **");
      $finish;
   end

endmodule
